>>> rtl/pts_pkg.sv
`timescale 1ns / 1ps

package pts_pkg;

    // Command codes carried on the request channel.
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_RESUME  = 3'd1;
    localparam logic [2:0] MODE_UNBLOCK = 3'd2;
    localparam logic [2:0] MODE_BLOCK   = 3'd3;
    localparam logic [2:0] MODE_SETPRI  = 3'd4;
    localparam logic [2:0] MODE_SCHED   = 3'd5;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_NONE  = 2'd2;

    // Task state codes.
    localparam logic [1:0] TS_SUSP  = 2'd0;
    localparam logic [1:0] TS_READY = 2'd1;
    localparam logic [1:0] TS_WAIT  = 2'd2;

    localparam logic [31:0] WAIT_FOREVER = 32'hFFFF_FFFF;

    // Number of task slots in the table.
    localparam int SLOT_MAX = 16;

    // Entries in the command queue between front and back.
    localparam int QDEPTH = 2;

    // Classified operation handed from the front to the back.
    typedef enum logic [2:0] {
        OP_TICK,
        OP_RESUME,
        OP_UNBLOCK,
        OP_BLOCK,
        OP_SETPRI,
        OP_SCHED,
        OP_RANGE,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  idx;
        logic [7:0]  prio;
        logic [31:0] delay;
    } t_cmd;

    // One word of the task table.
    typedef struct packed {
        logic [1:0]  state;
        logic [7:0]  prio;
        logic [31:0] tmo;
    } t_slot;

endpackage

>>> rtl/pts_if.sv
`timescale 1ns / 1ps

// Request channel: one kernel command.
interface pts_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [3:0]  task_index;
    logic [7:0]  priority_req;
    logic [31:0] delay;

    modport source (output valid, mode, task_index, priority_req, delay, input ready);
    modport sink   (input valid, mode, task_index, priority_req, delay, output ready);
endinterface

// Result channel: one result per request.
interface pts_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  task_index_res;
    logic [7:0]  priority_res;
    logic [31:0] tick_count;

    modport source (output valid, status, task_index_res, priority_res, tick_count,
                    input ready);
    modport sink   (input valid, status, task_index_res, priority_res, tick_count,
                    output ready);
endinterface

>>> rtl/pts_front.sv
`timescale 1ns / 1ps

module pts_front import pts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [4:0] i_task_count,
    pts_in_if.sink     i_req,
    output logic       o_valid,
    output t_cmd       o_cmd,
    input  logic       i_ready
);

    localparam int NW = $clog2(SLOT_MAX + 1);

    logic          r_valid;
    t_cmd          r_cmd;
    t_cmd          n_cmd;
    logic [NW-1:0] w_n;
    logic          w_oor;
    logic          w_take;

    // Number of slots in use, limited to the table size.
    assign w_n = (32'(i_task_count) > SLOT_MAX) ? NW'(SLOT_MAX) : NW'(i_task_count);
    assign w_oor = 32'(i_req.task_index) >= 32'(w_n);

    assign i_req.ready = !r_valid || i_ready;
    assign w_take      = i_req.valid && i_req.ready;

    // Classify the request into an operation for the back end.
    always_comb begin
        n_cmd.idx   = i_req.task_index;
        n_cmd.prio  = i_req.priority_req;
        n_cmd.delay = i_req.delay;
        unique case (i_req.mode)
            MODE_TICK:    n_cmd.op = OP_TICK;
            MODE_RESUME:  n_cmd.op = w_oor ? OP_RANGE : OP_RESUME;
            MODE_UNBLOCK: n_cmd.op = w_oor ? OP_RANGE : OP_UNBLOCK;
            MODE_BLOCK:   n_cmd.op = OP_BLOCK;
            MODE_SETPRI:  n_cmd.op = w_oor ? OP_RANGE : OP_SETPRI;
            MODE_SCHED:   n_cmd.op = OP_SCHED;
            default:      n_cmd.op = OP_NOP;
        endcase
    end

    // Holding register toward the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

>>> rtl/pts_fifo.sv
`timescale 1ns / 1ps

module pts_fifo import pts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PW = $clog2(QDEPTH);

    t_cmd            r_q [QDEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_ready = r_cnt != (PW+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_q[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (32'(r_wp) == QDEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (32'(r_rp) == QDEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

>>> rtl/pts_back.sv
`timescale 1ns / 1ps

module pts_back import pts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [4:0] i_task_count,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    pts_out_if.source  o_res
);

    localparam int IW = (SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1;
    localparam int NW = $clog2(SLOT_MAX + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_TICK,
        S_SCAN,
        S_PUT
    } t_state;

    // Task table with one valid bit per slot; an unwritten slot reads as zero.
    t_slot           r_mem [SLOT_MAX];
    logic            r_vld [SLOT_MAX];
    t_slot           r_rd;
    logic            r_rd_v;
    t_slot           w_slot;

    t_state          r_st, n_st;
    t_cmd            r_cmd, n_cmd;
    logic [IW-1:0]   r_ptr, n_ptr;
    logic [IW-1:0]   r_cnt, n_cnt;
    logic            r_found, n_found;
    logic [IW-1:0]   r_pick, n_pick;
    logic [7:0]      r_pick_pri, n_pick_pri;
    logic [31:0]     r_tick, n_tick;
    logic [IW-1:0]   r_last, n_last;
    logic [IW-1:0]   r_cur, n_cur;
    logic [1:0]      r_status, n_status;
    logic [3:0]      r_res_idx, n_res_idx;
    logic [7:0]      r_res_pri, n_res_pri;
    logic            r_ov, n_ov;
    logic [1:0]      r_o_status, n_o_status;
    logic [3:0]      r_o_idx, n_o_idx;
    logic [7:0]      r_o_pri, n_o_pri;
    logic [31:0]     r_o_tick, n_o_tick;

    logic [NW-1:0]   w_n;
    logic [IW-1:0]   w_last_idx;
    logic [IW:0]     w_first;
    logic [IW-1:0]   w_start;
    logic [IW:0]     w_step;
    logic [IW-1:0]   w_next;
    logic            w_out_free;
    logic            w_take;
    logic            w_found;
    logic [IW-1:0]   w_pick;
    logic [7:0]      w_pick_pri;
    logic [IW-1:0]   w_ra;
    logic            w_we;
    logic [IW-1:0]   w_wa;
    t_slot           w_wd;

    assign w_n        = (32'(i_task_count) > SLOT_MAX) ? NW'(SLOT_MAX) : NW'(i_task_count);
    assign w_last_idx = IW'(w_n - 1'b1);
    assign w_slot     = r_rd_v ? r_rd : '0;
    assign w_out_free = !r_ov || o_res.ready;
    assign o_cmd_pop  = (r_st == S_IDLE) && i_cmd_valid;

    // Round-robin scan starts just after the last task chosen.
    assign w_first = {1'b0, r_last} + 1'b1;
    assign w_start = (w_first >= (IW+1)'(w_n)) ? '0 : IW'(w_first);
    assign w_step  = {1'b0, r_ptr} + 1'b1;
    assign w_next  = (w_step >= (IW+1)'(w_n)) ? '0 : IW'(w_step);

    // Scan compare: a ready task of strictly higher priority replaces the pick.
    assign w_take     = (w_slot.state == TS_READY) && (!r_found || w_slot.prio > r_pick_pri);
    assign w_found    = r_found || w_take;
    assign w_pick     = w_take ? r_ptr : r_pick;
    assign w_pick_pri = w_take ? w_slot.prio : r_pick_pri;

    // Sequencer: next state, table access and result.
    always_comb begin
        n_st       = r_st;
        n_cmd      = r_cmd;
        n_ptr      = r_ptr;
        n_cnt      = r_cnt;
        n_found    = r_found;
        n_pick     = r_pick;
        n_pick_pri = r_pick_pri;
        n_tick     = r_tick;
        n_last     = r_last;
        n_cur      = r_cur;
        n_status   = r_status;
        n_res_idx  = r_res_idx;
        n_res_pri  = r_res_pri;
        n_ov       = r_ov && !o_res.ready;
        n_o_status = r_o_status;
        n_o_idx    = r_o_idx;
        n_o_pri    = r_o_pri;
        n_o_tick   = r_o_tick;
        w_ra       = r_ptr;
        w_we       = 1'b0;
        w_wa       = r_ptr;
        w_wd       = w_slot;

        unique case (r_st)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd     = i_cmd;
                    n_status  = STAT_OK;
                    n_res_idx = '0;
                    n_res_pri = '0;
                    unique case (i_cmd.op)
                        OP_TICK: begin
                            n_tick = r_tick + 1'b1;
                            n_ptr  = '0;
                            w_ra   = '0;
                            n_st   = (w_n == '0) ? S_PUT : S_TICK;
                        end
                        OP_RESUME, OP_UNBLOCK, OP_SETPRI: begin
                            w_ra = IW'(i_cmd.idx);
                            n_st = S_CMD;
                        end
                        OP_BLOCK: begin
                            if ((IW+1)'(r_cur) >= (IW+1)'(w_n)) begin
                                n_status  = STAT_RANGE;
                                n_res_idx = 4'(r_cur);
                                n_st      = S_PUT;
                            end else begin
                                w_ra = r_cur;
                                n_st = S_CMD;
                            end
                        end
                        OP_SCHED: begin
                            if (w_n == '0) begin
                                n_status = STAT_NONE;
                                n_last   = '0;
                                n_st     = S_PUT;
                            end else begin
                                n_ptr      = w_start;
                                w_ra       = w_start;
                                n_cnt      = '0;
                                n_found    = 1'b0;
                                n_pick     = '0;
                                n_pick_pri = '0;
                                n_st       = S_SCAN;
                            end
                        end
                        OP_RANGE: begin
                            n_status  = STAT_RANGE;
                            n_res_idx = i_cmd.idx;
                            n_st      = S_PUT;
                        end
                        default: begin
                            n_st = S_PUT;
                        end
                    endcase
                end
            end

            // Single-slot commands: the slot word arrived this cycle.
            S_CMD: begin
                w_we = 1'b1;
                w_wa = (r_cmd.op == OP_BLOCK) ? r_cur : IW'(r_cmd.idx);
                priority case (r_cmd.op)
                    OP_RESUME: begin
                        if (w_slot.state == TS_SUSP) begin
                            w_wd.state = TS_READY;
                        end
                    end
                    OP_UNBLOCK: begin
                        if (w_slot.state == TS_WAIT) begin
                            w_wd.state = TS_READY;
                        end
                    end
                    OP_SETPRI: begin
                        w_wd.prio = r_cmd.prio;
                    end
                    default: begin
                        w_wd.state = TS_WAIT;
                        w_wd.tmo   = r_cmd.delay;
                    end
                endcase
                n_res_idx = (r_cmd.op == OP_BLOCK) ? 4'(r_cur) : r_cmd.idx;
                n_res_pri = w_wd.prio;
                n_st      = S_PUT;
            end

            // Timeout sweep, one slot a cycle.
            S_TICK: begin
                w_we = 1'b1;
                w_wa = r_ptr;
                if (w_slot.state == TS_WAIT && w_slot.tmo != WAIT_FOREVER) begin
                    if (w_slot.tmo == '0) begin
                        w_wd.state = TS_READY;
                    end else begin
                        w_wd.tmo = w_slot.tmo - 1'b1;
                    end
                end
                if (r_ptr == w_last_idx) begin
                    n_st = S_PUT;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                    w_ra  = r_ptr + 1'b1;
                end
            end

            // Round-robin priority scan, one slot a cycle.
            S_SCAN: begin
                n_found    = w_found;
                n_pick     = w_pick;
                n_pick_pri = w_pick_pri;
                n_ptr      = w_next;
                w_ra       = w_next;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == w_last_idx) begin
                    n_last = w_pick;
                    if (w_found) begin
                        n_cur     = w_pick;
                        n_res_idx = 4'(w_pick);
                        n_res_pri = w_pick_pri;
                    end else begin
                        n_status  = STAT_NONE;
                        n_res_idx = '0;
                        n_res_pri = '0;
                    end
                    n_st = S_PUT;
                end
            end

            // Hand the result to the output register once it is free.
            S_PUT: begin
                if (w_out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_idx    = r_res_idx;
                    n_o_pri    = r_res_pri;
                    n_o_tick   = r_tick;
                    n_st       = S_IDLE;
                end
            end

            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    // State, kernel registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_tick <= 32'd1;
            r_last <= '0;
            r_cur  <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_tick <= n_tick;
            r_last <= n_last;
            r_cur  <= n_cur;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_ptr      <= n_ptr;
        r_cnt      <= n_cnt;
        r_found    <= n_found;
        r_pick     <= n_pick;
        r_pick_pri <= n_pick_pri;
        r_status   <= n_status;
        r_res_idx  <= n_res_idx;
        r_res_pri  <= n_res_pri;
        r_o_status <= n_o_status;
        r_o_idx    <= n_o_idx;
        r_o_pri    <= n_o_pri;
        r_o_tick   <= n_o_tick;
    end

    // Task table: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd   <= r_mem[w_ra];
        r_rd_v <= r_vld[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOT_MAX; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_we) begin
            r_vld[w_wa] <= 1'b1;
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.status         = r_o_status;
    assign o_res.task_index_res = r_o_idx;
    assign o_res.priority_res   = r_o_pri;
    assign o_res.tick_count     = r_o_tick;

endmodule

>>> rtl/priority_task_scheduler.sv
`timescale 1ns / 1ps

// Hardware task table and scheduler for a small real-time kernel.
// Requests arrive on i_req (valid/ready) carrying mode, task_index,
// priority_req and delay; each request gives exactly one result on o_res
// with status, task_index_res, priority_res and tick_count.
// i_cfg_we/i_cfg_wdata write the number of task slots in use; write it
// only while no request is in flight.
// A front stage classifies requests into a two-entry queue; the back end
// runs them one at a time against the task table memory, whose single
// read port and single write port set the pace.
// Tick and schedule walk every slot in use, one per cycle, before the
// result is offered; the back end takes no new command until it has
// handed that result on. Resume, unblock, set priority and block read
// their slot and write it back first; out-of-range and unused modes go straight to the result.
// Reset marks every slot suspended with priority and timeout zero, sets
// the tick counter to one and the slot count to 16; no sweep is needed.
// When the receiver stalls, the result holds in the output register, the
// back end stops once its next result is ready, and the queue and front
// fill before i_req.ready drops.

module priority_task_scheduler import pts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    pts_in_if.sink     i_req,
    pts_out_if.source  o_res
);

    logic [4:0] r_task_count;
    logic       w_f_valid;
    t_cmd       w_f_cmd;
    logic       w_q_ready;
    logic       w_q_valid;
    t_cmd       w_q_cmd;
    logic       w_pop;

    // Slot count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= 5'd16;
        end else if (i_cfg_we) begin
            r_task_count <= i_cfg_wdata;
        end
    end

    pts_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_count (r_task_count),
        .i_req        (i_req),
        .o_valid      (w_f_valid),
        .o_cmd        (w_f_cmd),
        .i_ready      (w_q_ready)
    );

    pts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_cmd   (w_f_cmd),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    pts_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_count (r_task_count),
        .i_cmd_valid  (w_q_valid),
        .i_cmd        (w_q_cmd),
        .o_cmd_pop    (w_pop),
        .o_res        (o_res)
    );

endmodule

>>> rtl/pts_checker.sv
`timescale 1ns / 1ps

module pts_checker import pts_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_status,
    input logic [3:0]  i_idx,
    input logic [7:0]  i_pri
);

    // A pending result stays offered until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result offered after reset");

    // Only the three defined status codes appear.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_status == STAT_OK || i_status == STAT_RANGE || i_status == STAT_NONE))
        else $error("undefined status");

    // No ready task reports zero index and priority.
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == STAT_NONE |-> i_idx == '0 && i_pri == '0)
        else $error("no-ready result carries a task");

    // An out-of-range result reports priority zero.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == STAT_RANGE |-> i_pri == '0)
        else $error("out-of-range result carries a priority");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_status (o_res.status),
    .i_idx    (o_res.task_index_res),
    .i_pri    (o_res.priority_res)
);
